// ===== design/oai_pkg.sv =====
package oai_pkg;

  // List geometry
  localparam int CAPACITY  = 64;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 7;
  localparam int CNT_W     = 7;
  localparam int GRP_SIZE  = 8;
  localparam int NUM_GRP   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_CELLS = NUM_GRP * GRP_SIZE;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef logic signed [WORD_W-1:0] word_t;

  // Operation codes carried by an item
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // Per-cell update command
  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_LOAD  = 3'd1,
    CELL_LEFT  = 3'd2,
    CELL_RIGHT = 3'd3,
    CELL_ZERO  = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      hit;
  } cell_ctrl_t;

  typedef struct packed {
    op_t              operation;
    logic [POS_W-1:0] position;
    word_t            data_value;
  } in_item_t;

  typedef struct packed {
    logic             error;
    word_t            read_value;
    logic [CNT_W-1:0] count;
  } out_item_t;

endpackage

// ===== design/oai_cell.sv =====
module oai_cell import oai_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  word_t      data_in,
  input  word_t      left_in,
  input  word_t      right_in,
  output word_t      val,
  output word_t      rd_out
);

  word_t val_r;
  word_t val_nxt;

  // Next entry value: keep, load, clear to zero, or take a neighbour's entry
  always_comb begin
    unique case (ctrl.cmd)
      CELL_HOLD:  val_nxt = val_r;
      CELL_LOAD:  val_nxt = data_in;
      CELL_LEFT:  val_nxt = left_in;
      CELL_RIGHT: val_nxt = right_in;
      CELL_ZERO:  val_nxt = '0;
      default:    val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  // Only the addressed cell puts its entry on the read tree
  assign rd_out = ctrl.hit ? val_r : '0;

endmodule

// ===== design/ordered_array_insert_remove.sv =====
// Channel   Ports                          Direction  Handshake
// input     start, busy, in_item           in         taken when start high, busy low
// result    out_valid, out_item            out        one-cycle strobe, no back-pressure
//
// One item may be taken every cycle; busy is always low.
// Each result is registered first at the group stage of the read tree, which reads the
// cells directly, and then at the output register behind the final OR stage.
// Insert and remove move every entry from the given position onward one cell along in the same cycle.
// Reset clears the count and the result strobe; entries are left as they are.
// The receiver cannot stall the result channel.
module ordered_array_insert_remove import oai_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic             accept;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             insert_ok;
  logic             remove_ok;
  logic             read_ok;
  logic             write_ok;
  logic             op_err;

  cell_ctrl_t       ctrl    [CAPACITY];
  word_t            cell_v  [CAPACITY];
  word_t            rd_vals [PAD_CELLS];
  logic [CAPACITY-1:0] hit_vec;

  word_t            grp_r   [NUM_GRP];
  word_t            grp_nxt [NUM_GRP];
  logic             vld1_r;
  logic             err1_r;
  logic [CNT_W-1:0] cnt1_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  word_t            rd_final;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Operation checks against the current fill count
  always_comb begin
    insert_ok = 1'b0;
    remove_ok = 1'b0;
    read_ok   = 1'b0;
    write_ok  = 1'b0;
    op_err    = 1'b1;
    count_nxt = count_r;
    unique case (in_item.operation)
      OP_INSERT: begin
        insert_ok = (in_item.position <= count_r) && (count_r < CAP_CNT);
        op_err    = ~insert_ok;
        if (insert_ok) count_nxt = count_r + CNT_W'(1);
      end
      OP_REMOVE: begin
        remove_ok = in_item.position < count_r;
        op_err    = ~remove_ok;
        if (remove_ok) count_nxt = count_r - CNT_W'(1);
      end
      OP_READ: begin
        read_ok = in_item.position < count_r;
        op_err  = ~read_ok;
      end
      OP_WRITE: begin
        write_ok = in_item.position < count_r;
        op_err   = ~write_ok;
      end
      OP_CLEAR: begin
        op_err    = 1'b0;
        count_nxt = '0;
      end
      default: op_err = 1'b1;
    endcase
  end

  // Row of cells, each with its own shift command
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [POS_W-1:0] IDX = POS_W'(i);
    word_t left_w;
    word_t right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_v[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_v[i+1];
    end

    always_comb begin
      ctrl[i].hit = accept && read_ok && (in_item.position == IDX);
      ctrl[i].cmd = CELL_HOLD;
      if (accept) begin
        if (insert_ok && (IDX > in_item.position))       ctrl[i].cmd = CELL_LEFT;
        else if (insert_ok && (IDX == in_item.position)) ctrl[i].cmd = CELL_LOAD;
        else if (write_ok && (IDX == in_item.position))  ctrl[i].cmd = CELL_LOAD;
        else if (remove_ok && (IDX >= in_item.position)) ctrl[i].cmd = CELL_RIGHT;
        else if (in_item.operation == OP_CLEAR)          ctrl[i].cmd = CELL_ZERO;
      end
    end

    assign hit_vec[i] = ctrl[i].hit;

    oai_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .data_in  (in_item.data_value),
      .left_in  (left_w),
      .right_in (right_w),
      .val      (cell_v[i]),
      .rd_out   (rd_vals[i])
    );
  end

  // Unused leaves of the read tree
  for (genvar p = CAPACITY; p < PAD_CELLS; p++) begin : g_pad
    assign rd_vals[p] = '0;
  end

  // Read tree, first stage: OR within each group of cells
  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    always_comb begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        grp_nxt[g] = grp_nxt[g] | rd_vals[g*GRP_SIZE + k];
      end
    end
    always_ff @(posedge clk) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  // Read tree, second stage: OR across the groups
  always_comb begin
    rd_final = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      rd_final = rd_final | grp_r[g];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      vld1_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) count_r <= count_nxt;
      vld1_r      <= accept;
      out_valid_r <= vld1_r;
    end
  end

  // Result payload pipeline
  always_ff @(posedge clk) begin
    err1_r                <= op_err;
    cnt1_r                <= count_nxt;
    out_item_r.error      <= err1_r;
    out_item_r.read_value <= rd_final;
    out_item_r.count      <= cnt1_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Every accepted item is followed by its result strobe
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("result missing two cycles after item");

  // The list never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("fill count above capacity");

  // A rejected item returns zero as its read value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.error) |-> (out_item.read_value == '0))
    else $error("read value not zero on error");

  // Only clear moves the count by more than one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.operation != OP_CLEAR) |=>
      (count_r == $past(count_r) || count_r == $past(count_r) + CNT_W'(1) ||
       count_r == $past(count_r) - CNT_W'(1)))
    else $error("fill count jumped");

  // At most one cell drives the read tree
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("several cells selected for read");

endmodule

// ===== bench/ordered_array_insert_remove_test.sv =====
module ordered_array_insert_remove_test;
  import oai_pkg::*;

  // Operation codes the block must reject
  localparam op_t OP_RSVD_5 = op_t'(3'd5);
  localparam op_t OP_RSVD_7 = op_t'(3'd7);

  localparam int HALF_PERIOD  = 10;
  localparam int RAND_ITEMS   = 1400;
  localparam int CALM_ITEMS   = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_ROWS     = 25;
  localparam int POS_MAX      = (1 << POS_W) - 1;

  // Shape of the random traffic: list growing, shrinking or churning
  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_SHRINK,
    MIX_CHURN
  } mix_t;

  // One row of directed stimulus; pinned rows carry their own result
  typedef struct {
    op_t              operation;
    logic [POS_W-1:0] position;
    word_t            data_value;
    bit               pinned;
    logic             error;
    word_t            read_value;
    logic [CNT_W-1:0] count;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      start     = 1'b0;
  in_item_t  in_item   = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // Shadow of the list contents and results still to come
  word_t     list_words[$];
  out_item_t pending_results[$];
  int        fail_count = 0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // empty list: everything but insert at the head and clear is refused
    '{OP_READ,    7'd0,   32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd0},
    '{OP_REMOVE,  7'd0,   32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd0},
    '{OP_WRITE,   7'd0,   32'h5555_AAAA, 1'b1, 1'b1, 32'h0, 7'd0},
    '{OP_INSERT,  7'd1,   32'h0000_0001, 1'b1, 1'b1, 32'h0, 7'd0},
    '{OP_CLEAR,   7'd0,   32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0},
    // extreme words at head and tail
    '{OP_INSERT,  7'd0,   32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, 7'd1},
    '{OP_INSERT,  7'd0,   32'h8000_0000, 1'b1, 1'b0, 32'h0, 7'd2},
    '{OP_INSERT,  7'd2,   32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 7'd3},
    '{OP_READ,    7'd0,   32'h0000_0000, 1'b1, 1'b0, 32'h8000_0000, 7'd3},
    '{OP_READ,    7'd1,   32'h0000_0000, 1'b1, 1'b0, 32'h7FFF_FFFF, 7'd3},
    '{OP_READ,    7'd2,   32'h0000_0000, 1'b1, 1'b0, 32'hFFFF_FFFF, 7'd3},
    // positions at and beyond the count
    '{OP_READ,    7'd3,   32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd3},
    '{OP_INSERT,  7'd4,   32'h1234_5678, 1'b1, 1'b1, 32'h0, 7'd3},
    '{OP_INSERT,  7'd1,   32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0},
    '{OP_READ,    7'd127, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd4},
    '{OP_WRITE,   7'd64,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 7'd4},
    // overwrite, then remove from the head and the top
    '{OP_WRITE,   7'd1,   32'h1234_5678, 1'b0, 1'b0, 32'h0, 7'd0},
    '{OP_READ,    7'd1,   32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0},
    '{OP_REMOVE,  7'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0},
    '{OP_READ,    7'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0},
    '{OP_REMOVE,  7'd2,   32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0},
    // unknown operations leave the list alone
    '{OP_RSVD_5,  7'd0,   32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd2},
    '{OP_RSVD_7,  7'd127, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 7'd2},
    '{OP_CLEAR,   7'd0,   32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0},
    '{OP_READ,    7'd0,   32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd0}
  };

  ordered_array_insert_remove dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #HALF_PERIOD clk = ~clk;

  // Apply one item to the shadow list and return the result it gives
  function automatic out_item_t list_update(input in_item_t it);
    out_item_t   res;
    int unsigned fill;
    fill           = list_words.size();
    res.error      = 1'b0;
    res.read_value = '0;
    case (it.operation)
      OP_INSERT: begin
        if (it.position > fill || fill >= CAPACITY) res.error = 1'b1;
        else list_words.insert(it.position, it.data_value);
      end
      OP_REMOVE: begin
        if (it.position >= fill) res.error = 1'b1;
        else list_words.delete(it.position);
      end
      OP_READ: begin
        if (it.position >= fill) res.error = 1'b1;
        else res.read_value = list_words[it.position];
      end
      OP_WRITE: begin
        if (it.position >= fill) res.error = 1'b1;
        else list_words[it.position] = it.data_value;
      end
      OP_CLEAR: list_words.delete();
      default: res.error = 1'b1;
    endcase
    res.count = CNT_W'(list_words.size());
    return res;
  endfunction

  // Random item: mostly in-range positions, with some anywhere in the field
  function automatic in_item_t random_item(input mix_t mix);
    in_item_t    it;
    int unsigned roll;
    int unsigned fill;
    int unsigned ins_cut;
    int unsigned rem_cut;
    fill = list_words.size();
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   begin ins_cut = 60; rem_cut = 70; end
      MIX_SHRINK: begin ins_cut = 10; rem_cut = 70; end
      default:    begin ins_cut = 30; rem_cut = 58; end
    endcase
    if (roll < ins_cut)       it.operation = OP_INSERT;
    else if (roll < rem_cut)  it.operation = OP_REMOVE;
    else if (roll < 83)       it.operation = OP_READ;
    else if (roll < 96)       it.operation = OP_WRITE;
    else if (roll < 97)       it.operation = OP_CLEAR;
    else it.operation = op_t'($urandom_range(OP_RSVD_5, OP_RSVD_7));
    if ($urandom_range(0, 99) < 12)
      it.position = POS_W'($urandom_range(0, POS_MAX));
    else if (it.operation == OP_INSERT)
      it.position = POS_W'($urandom_range(0, fill));
    else if (fill > 0)
      it.position = POS_W'($urandom_range(0, fill - 1));
    else
      it.position = '0;
    it.data_value = word_t'($urandom);
    return it;
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic push_item(input in_item_t it, input bit pinned, input out_item_t pinned_res);
    out_item_t predicted;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predicted = list_update(it);
    pending_results.push_back(pinned ? pinned_res : predicted);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 19)) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    in_item_t  it;
    out_item_t pinned_res;
    mix_t      mix;
    int        phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      it.operation          = directed_rows[r].operation;
      it.position           = directed_rows[r].position;
      it.data_value         = directed_rows[r].data_value;
      pinned_res.error      = directed_rows[r].error;
      pinned_res.read_value = directed_rows[r].read_value;
      pinned_res.count      = directed_rows[r].count;
      if ($urandom_range(0, 9) == 0) idle_burst();
      push_item(it, directed_rows[r].pinned, pinned_res);
    end

    // grow to full, churn, drain to empty, churn, and round again
    for (int n = 0; n < RAND_ITEMS; n++) begin
      phase = n % 500;
      if (phase < 150)      mix = MIX_GROW;
      else if (phase < 250) mix = MIX_CHURN;
      else if (phase < 400) mix = MIX_SHRINK;
      else                  mix = MIX_CHURN;
      if (n < RAND_ITEMS - CALM_ITEMS && $urandom_range(0, 99) < 8) idle_burst();
      push_item(random_item(mix), 1'b0, '0);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result checking against the oldest outstanding item
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: error=%0b read_value=%0d count=%0d",
               out_item.error, out_item.read_value, out_item.count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, out_item.error);
          fail_count++;
        end
        if (out_item.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_item.read_value);
          fail_count++;
        end
        if (out_item.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_item.count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
design/oai_pkg.sv
design/oai_cell.sv
design/ordered_array_insert_remove.sv
bench/ordered_array_insert_remove_test.sv
